// ===== rtl/core/dbe_pkg.sv =====
// Package for the dial box event decoder: types, codes and constants
// shared by the byte parser, the dial bank and the top level.
// No dependencies.
package dbe_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DBE_DIAL_COUNT   = 8;
    localparam int DBE_SWITCH_COUNT = 32;

    // Field widths fixed by the interface.
    localparam int IDX_W   = 5;
    localparam int VALUE_W = 16;
    localparam int NOISE_W = 15;
    localparam int MASK_W  = 33;
    localparam int CFG_IDX_W = 2;

    // Byte codes from the box.
    localparam logic [7:0] SWITCH_FLIP      = 8'h18;
    localparam logic [7:0] PEN_PRESS_BYTE   = 8'h2B;
    localparam logic [7:0] PEN_RELEASE_BYTE = 8'h2D;
    localparam int         PEN_MASK_BIT     = 32;

    // Half and full raw reading range, used by the unwrap correction.
    localparam logic signed [17:0] WRAP_HALF = 18'sd32768;
    localparam logic signed [17:0] WRAP_FULL = 18'sd65536;

    // Reset values of the configuration registers.
    localparam logic [7:0] DIAL_BASE_RESET    = 8'd48;
    localparam logic [7:0] PRESS_BASE_RESET   = 8'd192;
    localparam logic [7:0] RELEASE_BASE_RESET = 8'd224;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIAL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK  = 2'd3;

    // Input actions.
    localparam logic [1:0] ACT_BYTE   = 2'd0;
    localparam logic [1:0] ACT_LIMITS = 2'd1;
    localparam logic [1:0] ACT_VALUE  = 2'd2;

    // Report kinds.
    typedef enum logic [1:0] {
        KIND_DIAL   = 2'd0,
        KIND_SWITCH = 2'd1,
        KIND_PEN    = 2'd2
    } report_kind_t;

    // Byte parser state: how many message bytes are still expected.
    typedef enum logic [1:0] {
        WAIT_LOW    = 2'd0,
        WAIT_HIGH   = 2'd1,
        WAIT_HEADER = 2'd2
    } parse_state_t;

    // Completed dial message from the parser.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [15:0]       raw;
    } dial_msg_t;

    // Button event from the parser.
    typedef struct packed {
        logic              valid;
        report_kind_t      kind;
        logic [IDX_W-1:0]  idx;
        logic              pressed;
    } button_rpt_t;

    // Command to the dial bank for one item.
    typedef struct packed {
        logic                       msg_valid;
        logic                       set_limits;
        logic                       set_value;
        logic [IDX_W-1:0]           idx;
        logic [15:0]                raw;
        logic signed [VALUE_W-1:0]  min_limit;
        logic signed [VALUE_W-1:0]  max_limit;
        logic [NOISE_W-1:0]         noise;
        logic                       enable;
        logic signed [VALUE_W-1:0]  init_value;
    } dial_cmd_t;

    // Dial value report from the dial bank.
    typedef struct packed {
        logic                       valid;
        logic [IDX_W-1:0]           idx;
        logic signed [VALUE_W-1:0]  value;
    } dial_rpt_t;

endpackage

// ===== rtl/core/dbe_parser.sv =====
// Byte parser of the dial box event decoder: dial message framing and
// switch and light pen button decoding. Depends on dbe_pkg.
module dbe_parser
    import dbe_pkg::*;
#(
    parameter int DIAL_COUNT   = DBE_DIAL_COUNT,
    parameter int SWITCH_COUNT = DBE_SWITCH_COUNT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_fire,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        dial_code_base,
    input  logic [7:0]        press_code_base,
    input  logic [7:0]        release_code_base,
    input  logic [MASK_W-1:0] button_queue_mask,
    output dial_msg_t         dial_msg,
    output button_rpt_t       button_rpt
);

    parse_state_t state_reg, state_next;
    logic [7:0]   pend_dial_reg, pend_dial_next;
    logic [7:0]   pend_high_reg, pend_high_next;

    logic [7:0] hdr_offs, stale_offs, press_offs, release_offs;
    logic [7:0] press_sw, release_sw;
    logic       hdr_hit, stale_ok, press_hit, release_hit;

    // Range checks against the configured code bases, without wrap.
    always_comb begin
        hdr_offs     = rx_byte - dial_code_base;
        hdr_hit      = (rx_byte >= dial_code_base) &&
                       ({1'b0, hdr_offs} < 9'(DIAL_COUNT));
        stale_offs   = pend_dial_reg - dial_code_base;
        stale_ok     = (pend_dial_reg >= dial_code_base) &&
                       ({1'b0, stale_offs} < 9'(DIAL_COUNT));
        press_offs   = rx_byte - press_code_base;
        press_hit    = (rx_byte >= press_code_base) &&
                       ({1'b0, press_offs} < 9'(SWITCH_COUNT));
        release_offs = rx_byte - release_code_base;
        release_hit  = (rx_byte >= release_code_base) &&
                       ({1'b0, release_offs} < 9'(SWITCH_COUNT));
        press_sw     = press_offs ^ SWITCH_FLIP;
        release_sw   = release_offs ^ SWITCH_FLIP;
    end

    // Next state and event outputs.
    always_comb begin
        state_next     = state_reg;
        pend_dial_next = pend_dial_reg;
        pend_high_next = pend_high_reg;
        dial_msg       = '0;
        button_rpt     = '0;
        button_rpt.kind = KIND_SWITCH;
        if (byte_fire) begin
            case (state_reg)
                WAIT_HEADER: begin
                    if (hdr_hit) begin
                        pend_dial_next = rx_byte;
                        state_next     = WAIT_HIGH;
                    end else if (press_hit) begin
                        // Switch numbers of 32 and above have no queue bit.
                        button_rpt.valid   = (press_sw[7:5] == 3'd0) &&
                                             button_queue_mask[{1'b0, press_sw[4:0]}];
                        button_rpt.kind    = KIND_SWITCH;
                        button_rpt.idx     = press_sw[4:0];
                        button_rpt.pressed = 1'b1;
                    end else if (release_hit) begin
                        button_rpt.valid   = (release_sw[7:5] == 3'd0) &&
                                             button_queue_mask[{1'b0, release_sw[4:0]}];
                        button_rpt.kind    = KIND_SWITCH;
                        button_rpt.idx     = release_sw[4:0];
                        button_rpt.pressed = 1'b0;
                    end else if (rx_byte == PEN_PRESS_BYTE) begin
                        button_rpt.valid   = button_queue_mask[PEN_MASK_BIT];
                        button_rpt.kind    = KIND_PEN;
                        button_rpt.pressed = 1'b1;
                    end else if (rx_byte == PEN_RELEASE_BYTE) begin
                        button_rpt.valid   = button_queue_mask[PEN_MASK_BIT];
                        button_rpt.kind    = KIND_PEN;
                        button_rpt.pressed = 1'b0;
                    end
                end
                WAIT_HIGH: begin
                    pend_high_next = rx_byte;
                    state_next     = WAIT_LOW;
                end
                WAIT_LOW: begin
                    // A header that no longer names a dial drops the message.
                    state_next     = WAIT_HEADER;
                    dial_msg.valid = stale_ok;
                    dial_msg.idx   = stale_offs[IDX_W-1:0];
                    dial_msg.raw   = {pend_high_reg, rx_byte};
                end
                default: begin
                    state_next = WAIT_HEADER;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= WAIT_HEADER;
            pend_dial_reg <= 8'd0;
            pend_high_reg <= 8'd0;
        end else begin
            state_reg     <= state_next;
            pend_dial_reg <= pend_dial_next;
            pend_high_reg <= pend_high_next;
        end
    end

    // A completed message only ever leaves the low-byte state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dial_msg.valid |-> (state_reg == WAIT_LOW))
        else $error("dial message outside low-byte state");

    // Every byte taken in the low-byte state returns the parser to the header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_fire && state_reg == WAIT_LOW) |=> (state_reg == WAIT_HEADER))
        else $error("parser did not return to header state");

    // Button events never come out in the middle of a dial message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        button_rpt.valid |-> (state_reg == WAIT_HEADER))
        else $error("button event inside dial message");

endmodule

// ===== rtl/core/dbe_dial_bank.sv =====
// Per-dial state and the single-pass dial update: unwrap, clamp to the
// limits and noise filter. Depends on dbe_pkg.
module dbe_dial_bank
    import dbe_pkg::*;
#(
    parameter int DIAL_COUNT = DBE_DIAL_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dial_cmd_t cmd,
    output dial_rpt_t rpt
);

    localparam int AW = (DIAL_COUNT > 1) ? $clog2(DIAL_COUNT) : 1;

    // The dial value is kept as position minus offset; it always stays
    // within the 16-bit range after a message or a set action.
    logic signed [VALUE_W-1:0] value_reg    [DIAL_COUNT];
    logic [15:0]               raw_reg      [DIAL_COUNT];
    logic signed [VALUE_W-1:0] last_rep_reg [DIAL_COUNT];
    logic signed [VALUE_W-1:0] min_reg      [DIAL_COUNT];
    logic signed [VALUE_W-1:0] max_reg      [DIAL_COUNT];
    logic [NOISE_W-1:0]        noise_reg    [DIAL_COUNT];
    logic                      enable_reg   [DIAL_COUNT];

    logic [AW-1:0]             addr;
    logic signed [VALUE_W-1:0] cur_value, cur_last, cur_min, cur_max;
    logic signed [17:0]        step, delta, raw_sum;
    logic                      below, above;
    logic signed [VALUE_W-1:0] value_next, last_next;
    logic signed [17:0]        diff, neg_diff;
    logic                      moved;

    assign addr      = cmd.idx[AW-1:0];
    assign cur_value = value_reg[addr];
    assign cur_last  = last_rep_reg[addr];
    assign cur_min   = min_reg[addr];
    assign cur_max   = max_reg[addr];

    // Unwrap the raw step, then clamp; crossed limits end on the maximum.
    always_comb begin
        step = $signed({2'b00, cmd.raw}) - $signed({2'b00, raw_reg[addr]});
        if (step > WRAP_HALF) begin
            delta = step - WRAP_FULL;
        end else if (step < -WRAP_HALF) begin
            delta = step + WRAP_FULL;
        end else begin
            delta = step;
        end
        raw_sum = 18'(cur_value) + delta;
        below   = raw_sum < 18'(cur_min);
        above   = raw_sum > 18'(cur_max);
        if (below) begin
            value_next = (cur_min > cur_max) ? cur_max : cur_min;
        end else if (above) begin
            value_next = cur_max;
        end else begin
            value_next = raw_sum[VALUE_W-1:0];
        end
    end

    // Noise filter against the last reported value.
    always_comb begin
        diff      = 18'(value_next) - 18'(cur_last);
        neg_diff  = -diff;
        moved     = (diff >= $signed({3'b000, noise_reg[addr]})) ||
                    (neg_diff >= $signed({3'b000, noise_reg[addr]}));
        rpt.valid = cmd.msg_valid && enable_reg[addr] && moved;
        rpt.idx   = cmd.idx;
        rpt.value = value_next;
        last_next = (enable_reg[addr] && !moved) ? cur_last : value_next;
    end

    // Dial entry update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIAL_COUNT; i++) begin
                value_reg[i]    <= '0;
                raw_reg[i]      <= '0;
                last_rep_reg[i] <= '0;
                min_reg[i]      <= 16'sh8000;
                max_reg[i]      <= 16'sh7FFF;
                noise_reg[i]    <= '0;
                enable_reg[i]   <= 1'b0;
            end
        end else begin
            if (cmd.msg_valid) begin
                value_reg[addr]    <= value_next;
                raw_reg[addr]      <= cmd.raw;
                last_rep_reg[addr] <= last_next;
            end
            if (cmd.set_limits) begin
                min_reg[addr]    <= cmd.min_limit;
                max_reg[addr]    <= cmd.max_limit;
                noise_reg[addr]  <= cmd.noise;
                enable_reg[addr] <= cmd.enable;
            end
            if (cmd.set_value) begin
                value_reg[addr] <= cmd.init_value;
            end
        end
    end

    // A dial report is always clamped to the maximum limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rpt.valid |-> (rpt.value <= cur_max))
        else $error("dial report above maximum limit");

    // A dial report only comes from a completed message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rpt.valid |-> cmd.msg_valid)
        else $error("dial report without message");

    // A report updates the stored last value to the reported value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rpt.valid && !cmd.set_value) |=>
            (last_rep_reg[$past(addr)] == $past(value_next)))
        else $error("last reported value not updated");

endmodule

// ===== rtl/core/dial_box_event_decoder_core.sv =====
// Pipeline: an accepted item goes into the input register, then into the result
// register, from which it is taken on the result channel.
// Throughput: one item per cycle while m_ready is high; each item does at most
// one read-modify-write of a dial entry in the dial bank between the two registers.
// Reset (aresetn, synchronous, active low) restores register defaults,
// empties both stages and puts the parser back to waiting for a header.
module dial_box_event_decoder_core
    import dbe_pkg::*;
#(
    parameter int DIAL_COUNT   = DBE_DIAL_COUNT,
    parameter int SWITCH_COUNT = DBE_SWITCH_COUNT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write port.
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_idx,
    input  logic [MASK_W-1:0]         cfg_data,
    // Input channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_action,
    input  logic [7:0]                s_rx_byte,
    input  logic [2:0]                s_dial_index,
    input  logic signed [VALUE_W-1:0] s_min_limit,
    input  logic signed [VALUE_W-1:0] s_max_limit,
    input  logic [NOISE_W-1:0]        s_noise_threshold,
    input  logic                      s_report_enable,
    input  logic signed [VALUE_W-1:0] s_initial_value,
    // Result channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_report_valid,
    output logic [1:0]                m_report_kind,
    output logic [IDX_W-1:0]          m_report_index,
    output logic signed [VALUE_W-1:0] m_report_value
);

    // Configuration registers.
    logic [7:0]        dial_base_reg, press_base_reg, release_base_reg;
    logic [MASK_W-1:0] mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dial_base_reg    <= DIAL_BASE_RESET;
            press_base_reg   <= PRESS_BASE_RESET;
            release_base_reg <= RELEASE_BASE_RESET;
            mask_reg         <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_DIAL_BASE:    dial_base_reg    <= cfg_data[7:0];
                CFG_PRESS_BASE:   press_base_reg   <= cfg_data[7:0];
                CFG_RELEASE_BASE: release_base_reg <= cfg_data[7:0];
                CFG_BUTTON_MASK:  mask_reg         <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the result register frees up when it is empty or taken.
    logic in_valid_reg, out_valid_reg;
    logic out_load, fire;

    assign out_load = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;
    assign m_valid  = out_valid_reg;

    // Input register.
    logic [1:0]                action_reg;
    logic [7:0]                rx_byte_reg;
    logic [2:0]                dial_index_reg;
    logic signed [VALUE_W-1:0] min_reg, max_reg, init_reg;
    logic [NOISE_W-1:0]        noise_reg;
    logic                      enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg     <= s_action;
            rx_byte_reg    <= s_rx_byte;
            dial_index_reg <= s_dial_index;
            min_reg        <= s_min_limit;
            max_reg        <= s_max_limit;
            noise_reg      <= s_noise_threshold;
            enable_reg     <= s_report_enable;
            init_reg       <= s_initial_value;
        end
    end

    // Byte parser.
    dial_msg_t   dial_msg;
    button_rpt_t button_rpt;

    dbe_parser #(
        .DIAL_COUNT   (DIAL_COUNT),
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .byte_fire         (fire && (action_reg == ACT_BYTE)),
        .rx_byte           (rx_byte_reg),
        .dial_code_base    (dial_base_reg),
        .press_code_base   (press_base_reg),
        .release_code_base (release_base_reg),
        .button_queue_mask (mask_reg),
        .dial_msg          (dial_msg),
        .button_rpt        (button_rpt)
    );

    // Dial command: a completed message or a set action on a valid dial.
    dial_cmd_t dial_cmd;
    dial_rpt_t dial_rpt;
    logic      index_ok;

    always_comb begin
        index_ok            = {3'b000, dial_index_reg} < 6'(DIAL_COUNT);
        dial_cmd.msg_valid  = dial_msg.valid;
        dial_cmd.set_limits = fire && (action_reg == ACT_LIMITS) && index_ok;
        dial_cmd.set_value  = fire && (action_reg == ACT_VALUE) && index_ok;
        dial_cmd.idx        = dial_msg.valid ? dial_msg.idx : IDX_W'(dial_index_reg);
        dial_cmd.raw        = dial_msg.raw;
        dial_cmd.min_limit  = min_reg;
        dial_cmd.max_limit  = max_reg;
        dial_cmd.noise      = noise_reg;
        dial_cmd.enable     = enable_reg;
        dial_cmd.init_value = init_reg;
    end

    dbe_dial_bank #(
        .DIAL_COUNT (DIAL_COUNT)
    ) u_dial_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dial_cmd),
        .rpt     (dial_rpt)
    );

    // Result merge; fields are zero when no report is made.
    logic                      rep_valid_next;
    report_kind_t              rep_kind_next;
    logic [IDX_W-1:0]          rep_index_next;
    logic signed [VALUE_W-1:0] rep_value_next;

    always_comb begin
        rep_valid_next = 1'b0;
        rep_kind_next  = KIND_DIAL;
        rep_index_next = '0;
        rep_value_next = '0;
        if (dial_rpt.valid) begin
            rep_valid_next = 1'b1;
            rep_kind_next  = KIND_DIAL;
            rep_index_next = dial_rpt.idx;
            rep_value_next = dial_rpt.value;
        end else if (button_rpt.valid) begin
            rep_valid_next = 1'b1;
            rep_kind_next  = button_rpt.kind;
            rep_index_next = button_rpt.idx;
            rep_value_next = VALUE_W'(button_rpt.pressed);
        end
    end

    // Result register.
    logic                      rep_valid_reg;
    report_kind_t              rep_kind_reg;
    logic [IDX_W-1:0]          rep_index_reg;
    logic signed [VALUE_W-1:0] rep_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            rep_valid_reg <= rep_valid_next;
            rep_kind_reg  <= rep_kind_next;
            rep_index_reg <= rep_index_next;
            rep_value_reg <= rep_value_next;
        end
    end

    assign m_report_valid = rep_valid_reg;
    assign m_report_kind  = rep_kind_reg;
    assign m_report_index = rep_index_reg;
    assign m_report_value = rep_value_reg;

    // Every item that leaves the input register yields a result the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("item processed without result");

    // An empty result register never holds back the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |-> fire)
        else $error("input stalled with empty result register");

    // A result without a report carries all-zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_report_valid) |->
            (m_report_kind == KIND_DIAL && m_report_index == '0 &&
             m_report_value == '0))
        else $error("non-report result with nonzero fields");

    // Dial and button events never coincide on one item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(dial_rpt.valid && button_rpt.valid))
        else $error("dial and button event on one item");

endmodule

// ===== bench/dial_box_event_decoder_check.sv =====
// Scoreboard for the dial box event decoder: watches the configuration port and both
// channels, predicts one result per accepted item and compares it with the block's output.
// Depends on dbe_pkg for the field widths, codes and report kinds.
module dial_box_event_decoder_check
    import dbe_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_idx,
    input  logic [MASK_W-1:0]         cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [1:0]                s_action,
    input  logic [7:0]                s_rx_byte,
    input  logic [2:0]                s_dial_index,
    input  logic signed [VALUE_W-1:0] s_min_limit,
    input  logic signed [VALUE_W-1:0] s_max_limit,
    input  logic [NOISE_W-1:0]        s_noise_threshold,
    input  logic                      s_report_enable,
    input  logic signed [VALUE_W-1:0] s_initial_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_report_valid,
    input  logic [1:0]                m_report_kind,
    input  logic [IDX_W-1:0]          m_report_index,
    input  logic signed [VALUE_W-1:0] m_report_value,
    output int                        fail_count,
    output int                        results_due
);

    typedef struct packed {
        logic                       vld;
        report_kind_t               kind;
        logic [IDX_W-1:0]           idx;
        logic signed [VALUE_W-1:0]  value;
    } report_t;

    // Shadow copy of the configuration registers.
    logic [7:0]        dial_base;
    logic [7:0]        press_base;
    logic [7:0]        release_base;
    logic [MASK_W-1:0] queue_mask;

    // Shadow copy of the parser and the dial bank.
    parse_state_t              parse_stage;
    logic [7:0]                header_byte;
    logic [7:0]                high_byte;
    logic [31:0]               position   [DBE_DIAL_COUNT];
    logic [31:0]               offset     [DBE_DIAL_COUNT];
    logic [15:0]               last_raw   [DBE_DIAL_COUNT];
    logic signed [VALUE_W-1:0] last_value [DBE_DIAL_COUNT];
    logic signed [VALUE_W-1:0] min_lim    [DBE_DIAL_COUNT];
    logic signed [VALUE_W-1:0] max_lim    [DBE_DIAL_COUNT];
    logic [NOISE_W-1:0]        noise_lim  [DBE_DIAL_COUNT];
    logic                      rep_en     [DBE_DIAL_COUNT];

    report_t reports_due_q[$];
    int      errs = 0;

    // True when code lies in [base, base + span) without wrapping past 255.
    function automatic bit in_window(logic [7:0] code, logic [7:0] base, int span);
        int rel;
        rel = int'(code) - int'(base);
        return rel >= 0 && rel < span;
    endfunction

    // A button event is only reported when its queue bit is set.
    function automatic report_t button_report(int bit_no, report_kind_t kind, int idx,
                                              logic pressed);
        report_t r;
        r = '0;
        if (bit_no < MASK_W && queue_mask[bit_no]) begin
            r.vld   = 1'b1;
            r.kind  = kind;
            r.idx   = idx[IDX_W-1:0];
            r.value = {15'd0, pressed};
        end
        return r;
    endfunction

    // Apply one item to the shadow state and return the result it should give.
    function automatic report_t decode_item(logic [1:0] act, logic [7:0] code,
                                            logic [2:0] dsel,
                                            logic signed [VALUE_W-1:0] lo,
                                            logic signed [VALUE_W-1:0] hi,
                                            logic [NOISE_W-1:0] nz, logic en,
                                            logic signed [VALUE_W-1:0] init);
        report_t     r;
        int          d;
        int          sw;
        int          step;
        int          v;
        int          lo_i;
        int          hi_i;
        int          prev_i;
        int          nz_i;
        int          diff;
        logic [15:0] raw;
        logic [31:0] rel_pos;
        r = '0;
        case (act)
            ACT_BYTE: begin
                // Bytes of a message in progress always belong to it.
                if (parse_stage != WAIT_HEADER || in_window(code, dial_base, DBE_DIAL_COUNT)) begin
                    case (parse_stage)
                        WAIT_HEADER: begin
                            header_byte = code;
                            parse_stage = WAIT_HIGH;
                        end
                        WAIT_HIGH: begin
                            high_byte   = code;
                            parse_stage = WAIT_LOW;
                        end
                        default: begin
                            parse_stage = WAIT_HEADER;
                            // A header made stale by a register write drops the message.
                            if (in_window(header_byte, dial_base, DBE_DIAL_COUNT)) begin
                                d    = int'(header_byte) - int'(dial_base);
                                raw  = {high_byte, code};
                                step = int'(raw) - int'(last_raw[d]);
                                position[d] = position[d] + 32'(step);
                                if (step > WRAP_HALF)
                                    position[d] = position[d] - 32'(WRAP_FULL);
                                else if (step < -WRAP_HALF)
                                    position[d] = position[d] + 32'(WRAP_FULL);
                                last_raw[d] = raw;

                                // Pull the offset so the value stays inside the limits.
                                lo_i    = min_lim[d];
                                hi_i    = max_lim[d];
                                rel_pos = position[d] - offset[d];
                                v       = rel_pos;
                                if (v < lo_i)
                                    offset[d] = position[d] - 32'(lo_i);
                                rel_pos = position[d] - offset[d];
                                v       = rel_pos;
                                if (v > hi_i)
                                    offset[d] = position[d] - 32'(hi_i);
                                rel_pos = position[d] - offset[d];
                                v       = rel_pos;

                                // Report when enabled and the move reaches the noise threshold.
                                prev_i = last_value[d];
                                nz_i   = noise_lim[d];
                                diff   = v - prev_i;
                                if (!rep_en[d]) begin
                                    last_value[d] = v[15:0];
                                end else if (diff >= nz_i || -diff >= nz_i) begin
                                    r.vld         = 1'b1;
                                    r.kind        = KIND_DIAL;
                                    r.idx         = d[IDX_W-1:0];
                                    r.value       = v[15:0];
                                    last_value[d] = v[15:0];
                                end
                            end
                        end
                    endcase
                end else if (in_window(code, press_base, DBE_SWITCH_COUNT)) begin
                    sw = (int'(code) - int'(press_base)) ^ int'(SWITCH_FLIP);
                    if (sw < DBE_SWITCH_COUNT && sw < PEN_MASK_BIT)
                        r = button_report(sw, KIND_SWITCH, sw, 1'b1);
                end else if (in_window(code, release_base, DBE_SWITCH_COUNT)) begin
                    sw = (int'(code) - int'(release_base)) ^ int'(SWITCH_FLIP);
                    if (sw < DBE_SWITCH_COUNT && sw < PEN_MASK_BIT)
                        r = button_report(sw, KIND_SWITCH, sw, 1'b0);
                end else if (code == PEN_PRESS_BYTE) begin
                    r = button_report(PEN_MASK_BIT, KIND_PEN, 0, 1'b1);
                end else if (code == PEN_RELEASE_BYTE) begin
                    r = button_report(PEN_MASK_BIT, KIND_PEN, 0, 1'b0);
                end
            end
            ACT_LIMITS: begin
                if (dsel < DBE_DIAL_COUNT) begin
                    min_lim[dsel]   = lo;
                    max_lim[dsel]   = hi;
                    noise_lim[dsel] = nz;
                    rep_en[dsel]    = en;
                end
            end
            ACT_VALUE: begin
                if (dsel < DBE_DIAL_COUNT) begin
                    lo_i         = init;
                    offset[dsel] = position[dsel] - 32'(lo_i);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Track register writes, queue predictions on input and check every result.
    always @(posedge aclk) begin
        report_t want;
        if (!aresetn) begin
            dial_base    = DIAL_BASE_RESET;
            press_base   = PRESS_BASE_RESET;
            release_base = RELEASE_BASE_RESET;
            queue_mask   = '0;
            parse_stage  = WAIT_HEADER;
            header_byte  = '0;
            high_byte    = '0;
            for (int i = 0; i < DBE_DIAL_COUNT; i++) begin
                position[i]   = '0;
                offset[i]     = '0;
                last_raw[i]   = '0;
                last_value[i] = '0;
                min_lim[i]    = 16'sh8000;
                max_lim[i]    = 16'sh7FFF;
                noise_lim[i]  = '0;
                rep_en[i]     = 1'b0;
            end
            reports_due_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_DIAL_BASE:    dial_base    = cfg_data[7:0];
                    CFG_PRESS_BASE:   press_base   = cfg_data[7:0];
                    CFG_RELEASE_BASE: release_base = cfg_data[7:0];
                    CFG_BUTTON_MASK:  queue_mask   = cfg_data;
                    default: begin
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                if (reports_due_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result: expected none, actual valid %0b kind %0d index %0d value %0d",
                             $time, m_report_valid, m_report_kind, m_report_index, m_report_value);
                end else begin
                    want = reports_due_q.pop_front();
                    if (want.vld !== m_report_valid) begin
                        errs++;
                        $display("%0t: report_valid expected %0b actual %0b",
                                 $time, want.vld, m_report_valid);
                    end
                    if (want.kind !== m_report_kind) begin
                        errs++;
                        $display("%0t: report_kind expected %0d actual %0d",
                                 $time, want.kind, m_report_kind);
                    end
                    if (want.idx !== m_report_index) begin
                        errs++;
                        $display("%0t: report_index expected %0d actual %0d",
                                 $time, want.idx, m_report_index);
                    end
                    if (want.value !== m_report_value) begin
                        errs++;
                        $display("%0t: report_value expected %0d actual %0d",
                                 $time, want.value, m_report_value);
                    end
                end
            end

            if (s_valid && s_ready)
                reports_due_q.push_back(decode_item(s_action, s_rx_byte, s_dial_index,
                                                    s_min_limit, s_max_limit,
                                                    s_noise_threshold, s_report_enable,
                                                    s_initial_value));
        end
        fail_count  <= errs;
        results_due <= reports_due_q.size();
    end

endmodule

// ===== bench/tb_dial_box_event_decoder_core.sv =====
// Top of the dial box event decoder bench: clock, reset, register writes and item stimulus.
// Depends on dbe_pkg, dial_box_event_decoder_core and dial_box_event_decoder_check.
module tb_dial_box_event_decoder_core;
    import dbe_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         PHASE_ITEMS    = 100;
    localparam int         PHASE_COUNT    = 6;

    logic                      aclk              = 1'b0;
    logic                      aresetn           = 1'b0;
    logic                      cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_idx           = '0;
    logic [MASK_W-1:0]         cfg_data          = '0;
    logic                      s_valid           = 1'b0;
    logic [1:0]                s_action          = ACT_BYTE;
    logic [7:0]                s_rx_byte         = '0;
    logic [2:0]                s_dial_index      = '0;
    logic signed [VALUE_W-1:0] s_min_limit       = '0;
    logic signed [VALUE_W-1:0] s_max_limit       = '0;
    logic [NOISE_W-1:0]        s_noise_threshold = '0;
    logic                      s_report_enable   = 1'b0;
    logic signed [VALUE_W-1:0] s_initial_value   = '0;
    logic                      m_ready           = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic                      m_report_valid;
    logic [1:0]                m_report_kind;
    logic [IDX_W-1:0]          m_report_index;
    logic signed [VALUE_W-1:0] m_report_value;

    int         fail_count;
    int         results_due;
    int         cycle_cnt   = 0;
    bit         tx_idle_on  = 1'b1;
    bit         rx_idle_on  = 1'b1;
    bit         rx_hold_req = 1'b0;
    logic [7:0] dial_base_now    = DIAL_BASE_RESET;
    logic [7:0] press_base_now   = PRESS_BASE_RESET;
    logic [7:0] release_base_now = RELEASE_BASE_RESET;

    dial_box_event_decoder_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_rx_byte         (s_rx_byte),
        .s_dial_index      (s_dial_index),
        .s_min_limit       (s_min_limit),
        .s_max_limit       (s_max_limit),
        .s_noise_threshold (s_noise_threshold),
        .s_report_enable   (s_report_enable),
        .s_initial_value   (s_initial_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_valid    (m_report_valid),
        .m_report_kind     (m_report_kind),
        .m_report_index    (m_report_index),
        .m_report_value    (m_report_value)
    );

    dial_box_event_decoder_check u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_rx_byte         (s_rx_byte),
        .s_dial_index      (s_dial_index),
        .s_min_limit       (s_min_limit),
        .s_max_limit       (s_max_limit),
        .s_noise_threshold (s_noise_threshold),
        .s_report_enable   (s_report_enable),
        .s_initial_value   (s_initial_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_valid    (m_report_valid),
        .m_report_kind     (m_report_kind),
        .m_report_index    (m_report_index),
        .m_report_value    (m_report_value),
        .fail_count        (fail_count),
        .results_due       (results_due)
    );

    // Free-running clock.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: stop the run if it never drains.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, plus one long hold when requested.
    initial begin
        int hold_cnt;
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++)
                    @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one item, with an optional idle burst first, and wait for acceptance.
    task automatic send_item(logic [1:0] act, logic [7:0] code, logic [2:0] dsel,
                             logic [15:0] lo, logic [15:0] hi, logic [14:0] nz,
                             logic en, logic [15:0] init);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_action          <= act;
        s_rx_byte         <= code;
        s_dial_index      <= dsel;
        s_min_limit       <= lo;
        s_max_limit       <= hi;
        s_noise_threshold <= nz;
        s_report_enable   <= en;
        s_initial_value   <= init;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Unused fields carry random values so they get exercised too.
    task automatic send_byte(logic [7:0] code);
        send_item(ACT_BYTE, code, 3'($urandom), 16'($urandom), 16'($urandom),
                  15'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic send_limits(logic [2:0] dsel, logic [15:0] lo, logic [15:0] hi,
                               logic [14:0] nz, logic en);
        send_item(ACT_LIMITS, 8'($urandom), dsel, lo, hi, nz, en, 16'($urandom));
    endtask

    task automatic send_position(logic [2:0] dsel, logic [15:0] init);
        send_item(ACT_VALUE, 8'($urandom), dsel, 16'($urandom), 16'($urandom),
                  15'($urandom), 1'($urandom), init);
    endtask

    // A complete dial message: header, high byte, low byte.
    task automatic send_dial_msg(logic [2:0] dial_no, logic [15:0] raw);
        logic [7:0] header;
        header = dial_base_now + {5'd0, dial_no};
        send_byte(header);
        send_byte(raw[15:8]);
        send_byte(raw[7:0]);
    endtask

    // Hold the input off until every predicted result has come out.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers back to back; only called while the block is idle.
    task automatic set_regs(logic [7:0] dial_base, logic [7:0] press_base,
                            logic [7:0] release_base, logic [MASK_W-1:0] mask);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DIAL_BASE;
        cfg_data <= MASK_W'(dial_base);
        @(posedge aclk);
        cfg_idx  <= CFG_PRESS_BASE;
        cfg_data <= MASK_W'(press_base);
        @(posedge aclk);
        cfg_idx  <= CFG_RELEASE_BASE;
        cfg_data <= MASK_W'(release_base);
        @(posedge aclk);
        cfg_idx  <= CFG_BUTTON_MASK;
        cfg_data <= mask;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        dial_base_now    = dial_base;
        press_base_now   = press_base;
        release_base_now = release_base;
    endtask

    // Half the time all queue bits on, so that button reports are frequent.
    function automatic logic [MASK_W-1:0] pick_mask();
        if ($urandom_range(0, 1) == 0)
            return {MASK_W{1'b1}};
        return {1'($urandom_range(0, 1)), 32'($urandom)};
    endfunction

    // One random unit of stimulus; returns the number of items it sent, an unused action counting as none.
    task automatic random_unit(output int sent);
        int                  pick;
        logic [15:0]         raw;
        logic signed [15:0]  lo;
        logic signed [15:0]  hi;
        logic signed [15:0]  swap;
        logic [14:0]         nz;
        logic [7:0]          code;
        pick = $urandom_range(0, 99);
        sent = 1;
        if (pick < 55) begin
            // Well-formed message, readings biased toward the wrap points.
            raw = 16'($urandom);
            case ($urandom_range(0, 3))
                0: raw[15:8] = 8'h00;
                1: raw[15:8] = 8'hFF;
                2: raw[15:8] = 8'h7F + 8'($urandom_range(0, 1));
                default: begin
                end
            endcase
            send_dial_msg(3'($urandom_range(0, DBE_DIAL_COUNT - 1)), raw);
            sent = 3;
        end else if (pick < 70) begin
            lo = 16'($urandom);
            hi = 16'($urandom);
            if ($urandom_range(0, 9) < 7 && lo > hi) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            case ($urandom_range(0, 3))
                0, 1: nz = 15'($urandom_range(0, 16));
                2:    nz = 15'($urandom_range(0, 2000));
                default: nz = 15'($urandom);
            endcase
            send_limits(3'($urandom), lo, hi, nz, $urandom_range(0, 3) != 0);
        end else if (pick < 78) begin
            send_position(3'($urandom), 16'($urandom));
        end else if (pick < 92) begin
            case ($urandom_range(0, 2))
                0: code = press_base_now + 8'($urandom_range(0, DBE_SWITCH_COUNT - 1));
                1: code = release_base_now + 8'($urandom_range(0, DBE_SWITCH_COUNT - 1));
                default: code = $urandom_range(0, 1) ? PEN_PRESS_BYTE : PEN_RELEASE_BYTE;
            endcase
            send_byte(code);
        end else if (pick < 99) begin
            send_byte(8'($urandom));
        end else begin
            send_item(ACT_UNUSED, 8'($urandom), 3'($urandom), 16'($urandom),
                      16'($urandom), 15'($urandom), 1'($urandom), 16'($urandom));
            sent = 0;
        end
    endtask

    // Main stimulus and verdict.
    initial begin
        int units;
        int sent;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: wrap points, clamping, crossed limits, first and last switch codes, pen codes.
        set_regs(DIAL_BASE_RESET, PRESS_BASE_RESET, RELEASE_BASE_RESET, {MASK_W{1'b1}});
        send_limits(3'd0, 16'h8000, 16'h7FFF, 15'd0, 1'b1);
        send_dial_msg(3'd0, 16'h8000);
        send_dial_msg(3'd0, 16'h0001);
        send_dial_msg(3'd0, 16'hFFFF);
        send_limits(3'd7, 16'd100, -16'sd100, 15'h7FFF, 1'b1);
        send_dial_msg(3'd7, 16'h1234);
        send_position(3'd0, 16'h7FFF);
        send_position(3'd7, 16'h8000);
        send_byte(8'hC0);
        send_byte(8'hDF);
        send_byte(8'hE0);
        send_byte(8'hFF);
        send_byte(PEN_PRESS_BYTE);
        send_byte(PEN_RELEASE_BYTE);
        send_byte(8'h00);
        send_item(ACT_UNUSED, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, 16'hFFFF);
        // Bytes inside a message are taken as data even if they look like switch codes.
        send_byte(dial_base_now + 8'd1);
        send_byte(8'hC0);
        send_byte(8'hE0);
        // Header left pending across a register change, so the message goes stale.
        send_byte(dial_base_now + 8'd2);
        drain();
        set_regs(8'hFF, 8'h00, 8'h00, '0);
        send_byte(8'hC0);
        send_byte(8'hE0);
        send_dial_msg(3'd0, 16'h4000);
        send_byte(8'h05);
        send_byte(PEN_PRESS_BYTE);

        // Random part, one register setting per phase.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            case (phase)
                0: set_regs(DIAL_BASE_RESET, PRESS_BASE_RESET, RELEASE_BASE_RESET, pick_mask());
                2: set_regs(8'h00, 8'h00, 8'h20, {MASK_W{1'b1}});
                4: set_regs(8'hFC, 8'hFF, 8'hE8, pick_mask());
                5: set_regs(DIAL_BASE_RESET, PRESS_BASE_RESET, RELEASE_BASE_RESET,
                            {MASK_W{1'b1}});
                default: set_regs(8'($urandom), 8'($urandom), 8'($urandom), pick_mask());
            endcase
            tx_idle_on = (phase != 2 && phase != PHASE_COUNT - 1);
            rx_idle_on = tx_idle_on;
            // Long receiver hold so the block backs up into its input.
            if (phase == 1)
                rx_hold_req = 1'b1;
            units = 0;
            while (units < PHASE_ITEMS) begin
                random_unit(sent);
                units += sent;
            end
        end

        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
